### hw/rtl/nsc_pkg.sv
// shared constants, types and helpers for the nmea sentence checker
// no dependencies; imported by every module of the block

package nsc_pkg;

    // sentence length limit and the counter that follows it
    localparam int unsigned MAX_LEN   = 127;
    localparam int unsigned LIMIT_LEN = (MAX_LEN > 255) ? 255 : MAX_LEN;
    localparam int unsigned CNT_W     = $clog2(LIMIT_LEN + 1);

    // field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned TYPE_W   = 2;
    localparam int unsigned LEN_W    = 7;
    localparam int unsigned LEN_MAX  = (1 << LEN_W) - 1;
    localparam int unsigned RES_W    = 1 + TYPE_W + LEN_W;
    localparam int unsigned M_DATA_W = ((RES_W + 7) / 8) * 8;
    localparam int unsigned CFG_W    = 8;

    // character codes
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'd36;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'd42;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'd13;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'd57;
    localparam logic [BYTE_W-1:0] DIGIT_OFS = 8'd48;
    localparam logic [BYTE_W-1:0] ALPHA_OFS = 8'd55;

    // header bytes sit at these positions
    localparam int unsigned HDR_FIRST = 1;
    localparam int unsigned HDR_LAST  = 5;

    // sentence type codes
    localparam logic [TYPE_W-1:0] TYPE_UNKNOWN = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_GGA     = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_RMC     = 2'd2;

    // configuration register indexes and reset values
    localparam logic CFG_GGA_CODE = 1'b0;
    localparam logic CFG_RMC_CODE = 1'b1;
    localparam logic [CFG_W-1:0] GGA_CODE_RST = 8'd86;
    localparam logic [CFG_W-1:0] RMC_CODE_RST = 8'd75;

    // sentence state seen by the result logic
    typedef struct packed {
        logic              close;
        logic [CNT_W-1:0]  byte_count;
        logic [BYTE_W-1:0] running_xor;
        logic [BYTE_W-1:0] header_xor;
        logic [BYTE_W-1:0] previous_byte;
        logic [BYTE_W-1:0] last_byte;
        logic              overflowed;
    } nsc_status_t;

    // upper-case hex digit value, modulo 256
    function automatic logic [BYTE_W-1:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        if (c <= CH_NINE)
        begin
            v = c - DIGIT_OFS;
        end
        else
        begin
            v = c - ALPHA_OFS;
        end
        return v;
    endfunction

    // byte count saturated to the length field
    function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] c);
        logic [LEN_W-1:0] v;
        if (int'(c) > int'(LEN_MAX))
        begin
            v = LEN_W'(LEN_MAX);
        end
        else
        begin
            v = LEN_W'(c);
        end
        return v;
    endfunction

endpackage

### hw/rtl/nsc_tracker.sv
// per-byte sentence tracking: hunt, count, running and header xor
// depends on nsc_pkg

module nsc_tracker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [nsc_pkg::BYTE_W-1:0]  rx_byte,
    output nsc_pkg::nsc_status_t        status
);
    import nsc_pkg::*;

    logic              hunting_reg, hunting_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] run_xor_reg, run_xor_next;
    logic              star_reg, star_next;
    logic [BYTE_W-1:0] hdr_xor_reg, hdr_xor_next;
    logic              hdr_star_reg, hdr_star_next;
    logic [BYTE_W-1:0] prev_reg, prev_next;
    logic [BYTE_W-1:0] last_reg, last_next;
    logic              ovf_reg, ovf_next;

    logic is_star;
    logic is_dollar;
    logic in_header;

    assign is_star   = (rx_byte == CH_STAR);
    assign is_dollar = (rx_byte == CH_DOLLAR);
    assign in_header = (count_reg >= CNT_W'(HDR_FIRST)) && (count_reg <= CNT_W'(HDR_LAST));

    // next sentence state for the byte on the input
    always_comb
    begin
        hunting_next  = hunting_reg;
        count_next    = count_reg;
        run_xor_next  = run_xor_reg;
        star_next     = star_reg;
        hdr_xor_next  = hdr_xor_reg;
        hdr_star_next = hdr_star_reg;
        prev_next     = prev_reg;
        last_next     = last_reg;
        ovf_next      = ovf_reg;
        if (accept)
        begin
            if (hunting_reg)
            begin
                if (is_dollar)
                begin
                    hunting_next  = 1'b0;
                    count_next    = CNT_W'(1);
                    run_xor_next  = '0;
                    star_next     = 1'b0;
                    hdr_xor_next  = '0;
                    hdr_star_next = 1'b0;
                    prev_next     = '0;
                    last_next     = CH_DOLLAR;
                    ovf_next      = 1'b0;
                end
            end
            else if (rx_byte == CH_CR)
            begin
                hunting_next = 1'b1;
            end
            else
            begin
                if (count_reg >= CNT_W'(LIMIT_LEN))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (is_star)
                begin
                    star_next = 1'b1;
                end
                else if (!is_dollar && !star_reg)
                begin
                    run_xor_next = run_xor_reg ^ rx_byte;
                end
                if (in_header)
                begin
                    if (is_star)
                    begin
                        hdr_star_next = 1'b1;
                    end
                    else if (!is_dollar && !hdr_star_reg)
                    begin
                        hdr_xor_next = hdr_xor_reg ^ rx_byte;
                    end
                end
                prev_next = last_reg;
                last_next = rx_byte;
            end
        end
    end

    // sentence state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg  <= 1'b1;
            count_reg    <= '0;
            run_xor_reg  <= '0;
            star_reg     <= 1'b0;
            hdr_xor_reg  <= '0;
            hdr_star_reg <= 1'b0;
            prev_reg     <= '0;
            last_reg     <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            hunting_reg  <= hunting_next;
            count_reg    <= count_next;
            run_xor_reg  <= run_xor_next;
            star_reg     <= star_next;
            hdr_xor_reg  <= hdr_xor_next;
            hdr_star_reg <= hdr_star_next;
            prev_reg     <= prev_next;
            last_reg     <= last_next;
            ovf_reg      <= ovf_next;
        end
    end

    // status towards the result stage
    always_comb
    begin
        status.close         = !hunting_reg && (rx_byte == CH_CR);
        status.byte_count    = count_reg;
        status.running_xor   = run_xor_reg;
        status.header_xor    = hdr_xor_reg;
        status.previous_byte = prev_reg;
        status.last_byte     = last_reg;
        status.overflowed    = ovf_reg;
    end

endmodule

### hw/rtl/nsc_result.sv
// checksum compare, type decode and the registered result stage
// depends on nsc_pkg

module nsc_result (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  nsc_pkg::nsc_status_t          status,
    input  logic [nsc_pkg::CFG_W-1:0]     gga_header_code,
    input  logic [nsc_pkg::CFG_W-1:0]     rmc_header_code,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [nsc_pkg::M_DATA_W-1:0]  out_data
);
    import nsc_pkg::*;

    logic                valid_reg, valid_next;
    logic [RES_W-1:0]    res_reg, res_next;
    logic [BYTE_W-1:0]   hi_digit;
    logic [BYTE_W-1:0]   lo_digit;
    logic [BYTE_W-1:0]   chk;
    logic                chk_ok;
    logic [TYPE_W-1:0]   stype;

    // checksum from the two trailing hex digits
    always_comb
    begin
        hi_digit = hex_digit(status.previous_byte);
        lo_digit = hex_digit(status.last_byte);
        chk = {hi_digit[3:0], 4'b0000} + lo_digit;
        chk_ok = !status.overflowed
                 && (status.byte_count >= CNT_W'(3))
                 && (chk == status.running_xor);
    end

    // header code decode, gga wins on a tie
    always_comb
    begin
        stype = TYPE_UNKNOWN;
        if (chk_ok)
        begin
            if (status.header_xor == gga_header_code)
            begin
                stype = TYPE_GGA;
            end
            else if (status.header_xor == rmc_header_code)
            begin
                stype = TYPE_RMC;
            end
        end
    end

    // result register: load on a closing byte, drop when taken
    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        if (accept && status.close)
        begin
            valid_next = 1'b1;
            res_next   = {sat_len(status.byte_count), stype, chk_ok};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = M_DATA_W'(res_reg);

endmodule

### hw/rtl/nmea_sentence_checker.sv
// top level of the nmea sentence checker: config registers and handshake
// depends on nsc_pkg, nsc_tracker, nsc_result
//
//  channel  dir  fields (lsb first)                          handshake
//  s_*      in   tdata[7:0] rx_byte                          tvalid/tready
//  m_*      out  tdata[0] valid, [2:1] type, [9:3] length    tvalid/tready
//  cfg_*    in   index 0 gga code, 1 rmc code, data[7:0]     cfg_we
//
// one byte a cycle while s_tready is high; a result is ready the cycle after the closing cr
// the result register frees in the same cycle it is taken, so s_tready
// only drops while a result waits and m_tready is low
// reset clears the sentence state to hunting and the codes to 86 and 75

module nmea_sentence_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nsc_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nsc_pkg::M_DATA_W-1:0]  m_tdata,   // [0] sentence_valid,
                                                     // [2:1] sentence_type,
                                                     // [9:3] sentence_length
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [nsc_pkg::CFG_W-1:0]     cfg_data
);
    import nsc_pkg::*;

    logic [CFG_W-1:0] gga_code_reg;
    logic [CFG_W-1:0] rmc_code_reg;
    logic             accept;
    nsc_status_t      status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gga_code_reg <= GGA_CODE_RST;
            rmc_code_reg <= RMC_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GGA_CODE: gga_code_reg <= cfg_data;
                CFG_RMC_CODE: rmc_code_reg <= cfg_data;
                default:      gga_code_reg <= gga_code_reg;
            endcase
        end
    end

    // input request taken whenever the result slot is free or draining
    assign s_tready = !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;

    nsc_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_tdata),
        .status  (status)
    );

    nsc_result u_result (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .status          (status),
        .gga_header_code (gga_code_reg),
        .rmc_header_code (rmc_code_reg),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_data        (m_tdata)
    );

endmodule

### hw/rtl/nsc_checker.sv
// port-level assertions for the nmea sentence checker
// depends on nsc_pkg; bound to nmea_sentence_checker

module nsc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [nsc_pkg::BYTE_W-1:0]    s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [nsc_pkg::M_DATA_W-1:0]  m_tdata
);
    import nsc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input stalls only behind a waiting result
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting result");

    // a known type only on a valid sentence, never an undefined code
    a_type: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:1] == TYPE_UNKNOWN)
                     || (m_tdata[0] && (m_tdata[2:1] != 2'd3)))
        else $error("type set on invalid sentence");

    // a valid sentence is at least three bytes long
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[9:3] >= 7'd3)
        else $error("valid sentence too short");

    // a new result follows only an accepted cr
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tdata == CH_CR)))
        else $error("result without a closing cr");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/nmea_sentence_checker_chk.sv
// result checker for the nmea sentence checker testbench: tracks the sentence
// state from accepted bytes and register writes, and compares every result
// depends on nsc_pkg

`timescale 1ns / 100ps

module nmea_sentence_checker_chk (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [nsc_pkg::BYTE_W-1:0]    s_tdata,    // [7:0] rx_byte
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [nsc_pkg::M_DATA_W-1:0]  m_tdata,    // [0] sentence_valid,
                                                      // [2:1] sentence_type,
                                                      // [9:3] sentence_length
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [nsc_pkg::CFG_W-1:0]     cfg_data,
    output int                            fail_count,
    output int                            results_waiting,
    output int                            results_taken
);
    import nsc_pkg::*;

    typedef struct packed {
        logic              valid;
        logic [TYPE_W-1:0] stype;
        logic [LEN_W-1:0]  length;
    } sentence_result_t;

    // expected results, oldest first
    sentence_result_t sentence_q[$];

    // own copy of the header codes
    logic [CFG_W-1:0]  gga_code;
    logic [CFG_W-1:0]  rmc_code;

    // own copy of the sentence state
    logic              awaiting_dollar;
    logic [CNT_W-1:0]  bytes_in;
    logic [BYTE_W-1:0] body_xor;
    logic              body_star;
    logic [BYTE_W-1:0] hdr_xor;
    logic              hdr_star;
    logic [BYTE_W-1:0] prev_byte;
    logic [BYTE_W-1:0] newest_byte;
    logic              too_long;

    // value of an upper-case hex character, wrapping for anything else
    function automatic logic [BYTE_W-1:0] digit_value(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        if (c <= CH_NINE)
        begin
            v = c - DIGIT_OFS;
        end
        else
        begin
            v = c - ALPHA_OFS;
        end
        return v;
    endfunction

    // advance the sentence state by one byte; a closing cr queues a result
    task automatic track_byte(input logic [BYTE_W-1:0] b);
        sentence_result_t  res;
        logic [BYTE_W-1:0] sent_sum;
        int unsigned       pos;
        if (awaiting_dollar)
        begin
            if (b == CH_DOLLAR)
            begin
                awaiting_dollar = 1'b0;
                bytes_in        = CNT_W'(1);
                body_xor        = '0;
                body_star       = 1'b0;
                hdr_xor         = '0;
                hdr_star        = 1'b0;
                prev_byte       = '0;
                newest_byte     = CH_DOLLAR;
                too_long        = 1'b0;
            end
        end
        else if (b == CH_CR)
        begin
            res.valid  = 1'b0;
            res.stype  = TYPE_UNKNOWN;
            res.length = (int'(bytes_in) > int'(LEN_MAX)) ? LEN_W'(LEN_MAX)
                                                          : LEN_W'(bytes_in);
            if (!too_long && int'(bytes_in) >= 3)
            begin
                sent_sum  = (digit_value(prev_byte) << 4) + digit_value(newest_byte);
                res.valid = (sent_sum == body_xor);
            end
            // gga wins when both codes match
            if (res.valid)
            begin
                if (hdr_xor == gga_code)
                begin
                    res.stype = TYPE_GGA;
                end
                else if (hdr_xor == rmc_code)
                begin
                    res.stype = TYPE_RMC;
                end
            end
            sentence_q.push_back(res);
            awaiting_dollar = 1'b1;
        end
        else
        begin
            pos = 32'(bytes_in);
            // past the limit the count holds and the sentence is spoilt
            if (pos >= LIMIT_LEN)
            begin
                too_long = 1'b1;
            end
            else
            begin
                bytes_in = bytes_in + CNT_W'(1);
            end
            // checksum covers everything up to the first star, dollars aside
            if (b == CH_STAR)
            begin
                body_star = 1'b1;
            end
            else if (b != CH_DOLLAR && !body_star)
            begin
                body_xor = body_xor ^ b;
            end
            // header code from the address field only
            if (pos >= HDR_FIRST && pos <= HDR_LAST)
            begin
                if (b == CH_STAR)
                begin
                    hdr_star = 1'b1;
                end
                else if (b != CH_DOLLAR && !hdr_star)
                begin
                    hdr_xor = hdr_xor ^ b;
                end
            end
            prev_byte   = newest_byte;
            newest_byte = b;
        end
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        sentence_result_t want;
        sentence_result_t got;
        if (!rst_n)
        begin
            sentence_q.delete();
            gga_code        = GGA_CODE_RST;
            rmc_code        = RMC_CODE_RST;
            awaiting_dollar = 1'b1;
            bytes_in        = '0;
            body_xor        = '0;
            body_star       = 1'b0;
            hdr_xor         = '0;
            hdr_star        = 1'b0;
            prev_byte       = '0;
            newest_byte     = '0;
            too_long        = 1'b0;
            fail_count      = 0;
            results_waiting = 0;
            results_taken   = 0;
        end
        else
        begin
            // result request
            if (m_tvalid && m_tready)
            begin
                results_taken++;
                got.valid  = m_tdata[0];
                got.stype  = m_tdata[TYPE_W:1];
                got.length = m_tdata[TYPE_W+LEN_W:TYPE_W+1];
                if (sentence_q.size() == 0)
                begin
                    $error("result with nothing expected: valid %0d type %0d length %0d",
                           got.valid, got.stype, got.length);
                    fail_count++;
                end
                else
                begin
                    want = sentence_q.pop_front();
                    if (got.valid !== want.valid)
                    begin
                        $error("sentence_valid: expected %0d, got %0d", want.valid, got.valid);
                        fail_count++;
                    end
                    if (got.stype !== want.stype)
                    begin
                        $error("sentence_type: expected %0d, got %0d", want.stype, got.stype);
                        fail_count++;
                    end
                    if (got.length !== want.length)
                    begin
                        $error("sentence_length: expected %0d, got %0d",
                               want.length, got.length);
                        fail_count++;
                    end
                end
            end
            // register write
            if (cfg_we)
            begin
                if (cfg_index == CFG_GGA_CODE)
                begin
                    gga_code = cfg_data;
                end
                else
                begin
                    rmc_code = cfg_data;
                end
            end
            // byte request
            if (s_tvalid && s_tready)
            begin
                track_byte(s_tdata);
            end
            results_waiting = sentence_q.size();
        end
    end

endmodule

### tb/nmea_sentence_checker_tb.sv
// testbench top for the nmea sentence checker: clock, reset, byte and
// register stimulus, receiver stalls and the verdict
// depends on nsc_pkg, nmea_sentence_checker and nmea_sentence_checker_chk

`timescale 1ns / 100ps

module nmea_sentence_checker_tb;

    import nsc_pkg::*;

    localparam logic [BYTE_W-1:0] LOWER_OFS = 8'd87;    // 'a' - 10

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata   = '0;     // [7:0] rx_byte
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;            // [0] valid, [2:1] type, [9:3] length
    logic                cfg_we    = 1'b0;
    logic                cfg_index = CFG_GGA_CODE;
    logic [CFG_W-1:0]    cfg_data  = '0;

    int fail_count;
    int results_waiting;
    int results_taken;

    // idling odds in percent, long hold-off request and its counter
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_req       = 1'b0;
    int  hold_left      = 0;
    int  bytes_sent     = 0;

    // header codes as last written, for building matching headers
    logic [CFG_W-1:0]  gga_now = GGA_CODE_RST;
    logic [CFG_W-1:0]  rmc_now = RMC_CODE_RST;

    // bytes of the line being built
    logic [BYTE_W-1:0] line_q[$];

    nmea_sentence_checker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nmea_sentence_checker_chk u_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .results_waiting (results_waiting),
        .results_taken   (results_taken)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: long hold-off when asked, random stalls otherwise
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            m_tready = 1'b0;
            hold_left--;
        end
        else
        begin
            m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // offer one byte after a random gap and return at the edge that takes it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap++;
        end
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    task automatic send_line();
        foreach (line_q[i])
        begin
            send_byte(line_q[i]);
        end
    endtask

    // stop offering and wait for every expected result, then idle before returning
    task automatic drain(input int extra);
        int n;
        n = 0;
        @(negedge clk);
        s_tvalid = 1'b0;
        while (results_waiting != 0 && n < 20000)
        begin
            @(negedge clk);
            n++;
        end
        repeat (extra) @(negedge clk);
    endtask

    // both header codes, starting and ending at a falling edge
    task automatic write_codes(input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] r);
        cfg_we    = 1'b1;
        cfg_index = CFG_GGA_CODE;
        cfg_data  = g;
        @(negedge clk);
        cfg_index = CFG_RMC_CODE;
        cfg_data  = r;
        @(negedge clk);
        cfg_we  = 1'b0;
        gga_now = g;
        rmc_now = r;
    endtask

    // printable field byte that never opens, stars or closes a sentence
    function automatic logic [BYTE_W-1:0] field_char();
        logic [BYTE_W-1:0] c;
        do
        begin
            c = BYTE_W'($urandom_range(32, 126));
        end
        while (c == CH_STAR || c == CH_DOLLAR);
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n, input bit lower);
        logic [BYTE_W-1:0] c;
        if (n < 4'd10)
        begin
            c = DIGIT_OFS + n;
        end
        else
        begin
            c = (lower ? LOWER_OFS : ALPHA_OFS) + n;
        end
        return c;
    endfunction

    // one sentence into line_q; a non-zero fill_to pads it to that many
    // bytes before the cr, or one fewer when the star is left out
    task automatic build_sentence(input int fill_to);
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] sum;
        int                hk;
        int                p;
        int                n;
        bit                star_hit;
        bit                lower;
        line_q = {};
        line_q.push_back(CH_DOLLAR);
        hk = $urandom_range(0, 5);
        // address field
        case (hk)
            0, 1:
            begin
                // header meant to hit the gga or rmc code
                sum = '0;
                for (int i = 0; i < 4; i++)
                begin
                    c = field_char();
                    sum ^= c;
                    line_q.push_back(c);
                end
                c = sum ^ ((hk == 0) ? gga_now : rmc_now);
                if (c == CH_STAR || c == CH_DOLLAR || c == CH_CR)
                begin
                    c = field_char();
                end
                line_q.push_back(c);
            end
            2:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    line_q.push_back(field_char());
                end
            end
            3:
            begin
                // short header, data fields follow straight away
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                begin
                    line_q.push_back(field_char());
                end
            end
            4:
            begin
                // dollar inside the header
                p = $urandom_range(0, 4);
                for (int i = 0; i < 5; i++)
                begin
                    line_q.push_back((i == p) ? CH_DOLLAR : field_char());
                end
            end
            default:
            begin
                // star inside the header
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                begin
                    line_q.push_back(field_char());
                end
                line_q.push_back(CH_STAR);
            end
        endcase
        // data fields
        if (fill_to > 0)
        begin
            while (line_q.size() < fill_to - 3)
            begin
                line_q.push_back(field_char());
            end
        end
        else
        begin
            n = $urandom_range(0, 14);
            for (int i = 0; i < n; i++)
            begin
                line_q.push_back(($urandom_range(0, 19) == 0) ? CH_DOLLAR : field_char());
            end
        end
        // checksum over the bytes between the dollar and the first star
        sum      = '0;
        star_hit = 1'b0;
        for (int i = 1; i < line_q.size() && !star_hit; i++)
        begin
            if (line_q[i] == CH_STAR)
            begin
                star_hit = 1'b1;
            end
            else if (line_q[i] != CH_DOLLAR)
            begin
                sum ^= line_q[i];
            end
        end
        // sometimes a bad sum, lower-case digits or a missing star
        if ($urandom_range(0, 9) == 0)
        begin
            sum ^= BYTE_W'(1 << $urandom_range(0, 7));
        end
        lower = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 19) != 0)
        begin
            line_q.push_back(CH_STAR);
        end
        line_q.push_back(hex_char(sum[7:4], lower));
        line_q.push_back(hex_char(sum[3:0], lower));
        line_q.push_back(CH_CR);
    endtask

    // run limit
    initial
    begin
        #2000000;
        $display("nmea_sentence_checker_tb NOT OK");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        int                ph;
        int                r;
        int                phase_start;
        logic [CFG_W-1:0]  c;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed: byte extremes, cr while hunting, short, gga and rmc
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_CR);
        send_byte(CH_DOLLAR);
        send_byte(CH_CR);
        send_text("$GPGGA*56");
        send_byte(CH_CR);
        send_text("$GPRMC*4B");
        send_byte(CH_CR);

        // receiver holds off while sentences keep coming, then all drain
        drain(4);
        hold_req = 1'b1;
        for (int k = 0; k < 6; k++)
        begin
            build_sentence(0);
            send_line();
        end
        drain(4);

        // random phases, each with its own codes and idling
        ph = 0;
        while (bytes_sent < 725 || results_taken < 48)
        begin
            if (ph > 0)
            begin
                drain(4);
            end
            case (ph)
                0:
                begin
                    write_codes(GGA_CODE_RST, RMC_CODE_RST);
                end
                1:
                begin
                    write_codes(8'h00, 8'hFF);
                end
                2:
                begin
                    write_codes(8'hFF, 8'h00);
                end
                3:
                begin
                    c = CFG_W'($urandom);
                    write_codes(c, c);
                end
                default:
                begin
                    write_codes(CFG_W'($urandom), CFG_W'($urandom));
                end
            endcase
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 74;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 74;
                end
                default:
                begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 140)
            begin
                r = $urandom_range(0, 99);
                if (r < 68)
                begin
                    build_sentence(0);
                    send_line();
                end
                else if (r < 80)
                begin
                    // line noise, any byte value
                    repeat ($urandom_range(1, 10))
                    begin
                        send_byte(BYTE_W'($urandom_range(0, 255)));
                    end
                end
                else if (r < 87)
                begin
                    // sentence too short to carry a checksum
                    send_byte(CH_DOLLAR);
                    repeat ($urandom_range(0, 2))
                    begin
                        send_byte(field_char());
                    end
                    send_byte(CH_CR);
                end
                else if (r < 95)
                begin
                    // sentence cut before its cr, the next one runs into it
                    build_sentence(0);
                    void'(line_q.pop_back());
                    send_line();
                end
                else
                begin
                    // around the length limit and well past it
                    case ($urandom_range(0, 3))
                        0:       build_sentence(LIMIT_LEN - 1);
                        1:       build_sentence(LIMIT_LEN);
                        2:       build_sentence(LIMIT_LEN + 1);
                        default: build_sentence($urandom_range(LIMIT_LEN + 2, LIMIT_LEN + 40));
                    endcase
                    send_line();
                end
            end
            // close whatever is open so the phase ends hunting
            send_byte(CH_CR);
            ph++;
        end

        drain(8);
        if (fail_count == 0 && results_waiting == 0)
        begin
            $display("nmea_sentence_checker_tb OK");
        end
        else
        begin
            $display("nmea_sentence_checker_tb NOT OK");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/nsc_pkg.sv
hw/rtl/nsc_tracker.sv
hw/rtl/nsc_result.sv
hw/rtl/nmea_sentence_checker.sv
hw/rtl/nsc_checker.sv
tb/nmea_sentence_checker_chk.sv
tb/nmea_sentence_checker_tb.sv
